[hdl/ordered_list_engine_core_macros.svh]
// Assertion macros for the ordered list engine.
// Each macro samples on the rising edge of clock and is disabled during reset.
`ifndef ORDERED_LIST_ENGINE_CORE_MACROS_SVH
`define ORDERED_LIST_ENGINE_CORE_MACROS_SVH
`ifndef SYNTH
// The condition holds at every clock edge.
`define OLE_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
// When the trigger holds, the consequence holds at the next clock edge.
`define OLE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define OLE_ASSERT(label, cond, msg)
`define OLE_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[hdl/ole_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ole_pkg;

   // Store geometry.
   localparam int DEPTH     = 64;
   localparam int SLOT_BITS = 6;
   localparam int CNT_BITS  = 7;
   localparam int DATA_BITS = 32;

   // Request kinds.
   typedef enum logic [2:0] {
      OP_FRONT = 3'd0,
      OP_BACK  = 3'd1,
      OP_AT    = 3'd2,
      OP_ERASE = 3'd3,
      OP_FIND  = 3'd4
   } op_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_MISSING = 2'd1,
      ST_RANGE   = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_SLOT,
      S_FIX_FRONT,
      S_FIX_BACK,
      S_WALK,
      S_MID_A,
      S_MID_B,
      S_SRCH,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

[hdl/ordered_list_engine_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake             Payload
// req_      in         req_valid, req_stall  req_opcode, req_position, req_item_value
// rsp_      out        rsp_valid, rsp_stall  rsp_status, rsp_length
//
// One request is handled at a time. Front and back inserts pass the slot and fix
// states on to the result register (an empty list skips the fix); errors and unused
// codes go straight to it, and a positional insert walks to the insert point first.
// Erase and find walk at most the list length, reading one linked slot a cycle from
// the value, next and previous link memories, whose read port sets the pace. Reset
// clears the list at once; there is no clearing pass. A request is taken while an
// earlier result waits; a stalled result only holds the finishing step.

`include "ordered_list_engine_core_macros.svh"

module ordered_list_engine_core (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [2:0]                          req_opcode,
   input  wire  [ole_pkg::CNT_BITS-1:0]        req_position,
   input  wire  signed [31:0]                  req_item_value,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [ole_pkg::CNT_BITS-1:0]        rsp_length
);

   localparam int SB = ole_pkg::SLOT_BITS;
   localparam int CB = ole_pkg::CNT_BITS;
   localparam int DB = ole_pkg::DATA_BITS;

   // Memories holding values and links, plus the stack of released slots.
   logic [DB-1:0] val_mem [ole_pkg::DEPTH];
   logic [SB-1:0] nxt_mem [ole_pkg::DEPTH];
   logic [SB-1:0] prv_mem [ole_pkg::DEPTH];
   logic [SB-1:0] stk_mem [ole_pkg::DEPTH];

   ole_pkg::state_type  state_ff, state_in;
   ole_pkg::status_type status_ff, status_in;
   logic [2:0]    op_ff, op_in;
   logic [CB-1:0] pos_ff, pos_in;
   logic [DB-1:0] val_ff, val_in;
   logic [CB-1:0] count_ff, count_in;
   logic [SB-1:0] first_ff, first_in;
   logic [SB-1:0] last_ff, last_in;
   logic [CB-1:0] bump_ff, bump_in;
   logic [CB-1:0] sp_ff, sp_in;
   logic [SB-1:0] slot_ff, slot_in;
   logic [SB-1:0] cur_ff, cur_in;
   logic [SB-1:0] after_ff, after_in;
   logic [CB-1:0] steps_ff, steps_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [CB-1:0] rsp_length_ff, rsp_length_in;

   logic [DB-1:0] val_rd_ff;
   logic [SB-1:0] nxt_rd_ff, prv_rd_ff, stk_rd_ff;

   logic          val_we, nxt_we, prv_we, stk_we;
   logic [SB-1:0] val_wa, nxt_wa, prv_wa;
   logic [DB-1:0] val_wd;
   logic [SB-1:0] nxt_wd, prv_wd;
   logic [SB-1:0] rd_addr;
   logic [SB-1:0] stk_raddr;
   logic [SB-1:0] slot_c;
   logic [CB-1:0] pos_eff;
   logic          accept, out_free, is_first, is_last;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign stk_raddr = sp_ff[SB-1:0] - 1'b1;
   assign slot_c   = (bump_ff < CB'(ole_pkg::DEPTH)) ? bump_ff[SB-1:0] : stk_rd_ff;
   assign is_first = (cur_ff == first_ff);
   assign is_last  = (cur_ff == last_ff);

   // Effective insert position for the incoming request.
   always_comb begin
      case (req_opcode)
         ole_pkg::OP_FRONT: pos_eff = '0;
         ole_pkg::OP_BACK:  pos_eff = count_ff;
         default:           pos_eff = req_position;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ole_pkg::S_IDLE: begin
            if (accept) begin
               if (req_opcode == ole_pkg::OP_FRONT || req_opcode == ole_pkg::OP_BACK ||
                   req_opcode == ole_pkg::OP_AT) begin
                  if (pos_eff > count_ff || count_ff == CB'(ole_pkg::DEPTH)) begin
                     state_in = ole_pkg::S_DONE;
                  end else begin
                     state_in = ole_pkg::S_SLOT;
                  end
               end else if (req_opcode == ole_pkg::OP_ERASE ||
                            req_opcode == ole_pkg::OP_FIND) begin
                  state_in = ole_pkg::S_SRCH;
               end else begin
                  state_in = ole_pkg::S_DONE;
               end
            end
         end
         ole_pkg::S_SLOT: begin
            if (count_ff == '0) begin
               state_in = ole_pkg::S_DONE;
            end else if (pos_ff == '0) begin
               state_in = ole_pkg::S_FIX_FRONT;
            end else if (pos_ff >= count_ff) begin
               state_in = ole_pkg::S_FIX_BACK;
            end else begin
               state_in = ole_pkg::S_WALK;
            end
         end
         ole_pkg::S_FIX_FRONT, ole_pkg::S_FIX_BACK, ole_pkg::S_MID_B: begin
            state_in = ole_pkg::S_DONE;
         end
         ole_pkg::S_WALK: begin
            if (steps_ff == '0) state_in = ole_pkg::S_MID_A;
         end
         ole_pkg::S_MID_A: state_in = ole_pkg::S_MID_B;
         ole_pkg::S_SRCH: begin
            if (steps_ff == count_ff || val_rd_ff == val_ff) state_in = ole_pkg::S_DONE;
         end
         ole_pkg::S_DONE: begin
            if (out_free) state_in = ole_pkg::S_IDLE;
         end
         default: state_in = ole_pkg::S_IDLE;
      endcase
   end

   // Datapath and memory controls for each state.
   always_comb begin
      op_in     = op_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      status_in = status_ff;
      count_in  = count_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      bump_in   = bump_ff;
      sp_in     = sp_ff;
      slot_in   = slot_ff;
      after_in  = after_ff;
      steps_in  = steps_ff;
      rd_addr   = cur_ff;
      val_we = 1'b0; val_wa = slot_c;  val_wd = val_ff;
      nxt_we = 1'b0; nxt_wa = slot_ff; nxt_wd = '0;
      prv_we = 1'b0; prv_wa = slot_ff; prv_wd = '0;
      stk_we = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_length_in = rsp_length_ff;
      req_stall = (state_ff != ole_pkg::S_IDLE);
      unique case (state_ff)
         ole_pkg::S_IDLE: begin
            if (accept) begin
               op_in     = req_opcode;
               pos_in    = pos_eff;
               val_in    = DB'(req_item_value);
               status_in = ole_pkg::ST_OK;
               steps_in  = '0;
               rd_addr   = first_ff;
               if (req_opcode == ole_pkg::OP_FRONT || req_opcode == ole_pkg::OP_BACK ||
                   req_opcode == ole_pkg::OP_AT) begin
                  if (pos_eff > count_ff) begin
                     status_in = ole_pkg::ST_RANGE;
                  end else if (count_ff == CB'(ole_pkg::DEPTH)) begin
                     status_in = ole_pkg::ST_FULL;
                  end
               end
            end
         end
         // Take a slot, store the value and set its own links (a positional insert sets them after the walk).
         ole_pkg::S_SLOT: begin
            slot_in = slot_c;
            val_we  = 1'b1;
            nxt_wa  = slot_c;
            prv_wa  = slot_c;
            if (bump_ff < CB'(ole_pkg::DEPTH)) begin
               bump_in = bump_ff + 1'b1;
            end else begin
               sp_in = sp_ff - 1'b1;
            end
            if (count_ff == '0) begin
               nxt_we   = 1'b1;
               prv_we   = 1'b1;
               first_in = slot_c;
               last_in  = slot_c;
               count_in = count_ff + 1'b1;
            end else if (pos_ff == '0) begin
               nxt_we = 1'b1;
               nxt_wd = first_ff;
               prv_we = 1'b1;
            end else if (pos_ff >= count_ff) begin
               nxt_we = 1'b1;
               prv_we = 1'b1;
               prv_wd = last_ff;
            end else begin
               rd_addr  = first_ff;
               steps_in = pos_ff - 1'b1;
            end
         end
         ole_pkg::S_FIX_FRONT: begin
            prv_we   = 1'b1;
            prv_wa   = first_ff;
            prv_wd   = slot_ff;
            first_in = slot_ff;
            count_in = count_ff + 1'b1;
         end
         ole_pkg::S_FIX_BACK: begin
            nxt_we   = 1'b1;
            nxt_wa   = last_ff;
            nxt_wd   = slot_ff;
            last_in  = slot_ff;
            count_in = count_ff + 1'b1;
         end
         // Follow next links until the slot before the insert point.
         ole_pkg::S_WALK: begin
            if (steps_ff == '0) begin
               after_in = nxt_rd_ff;
            end else begin
               rd_addr  = nxt_rd_ff;
               steps_in = steps_ff - 1'b1;
            end
         end
         ole_pkg::S_MID_A: begin
            nxt_we = 1'b1;
            nxt_wd = after_ff;
            prv_we = 1'b1;
            prv_wd = cur_ff;
         end
         ole_pkg::S_MID_B: begin
            nxt_we   = 1'b1;
            nxt_wa   = cur_ff;
            nxt_wd   = slot_ff;
            prv_we   = 1'b1;
            prv_wa   = after_ff;
            prv_wd   = slot_ff;
            count_in = count_ff + 1'b1;
         end
         // Compare one linked entry a cycle; unlink on an erase match.
         ole_pkg::S_SRCH: begin
            if (steps_ff == count_ff) begin
               status_in = ole_pkg::ST_MISSING;
            end else if (val_rd_ff == val_ff) begin
               if (op_ff == ole_pkg::OP_ERASE) begin
                  stk_we   = 1'b1;
                  sp_in    = sp_ff + 1'b1;
                  count_in = count_ff - 1'b1;
                  if (is_first && is_last) begin
                     first_in = '0;
                     last_in  = '0;
                  end else if (is_first) begin
                     first_in = nxt_rd_ff;
                  end else if (is_last) begin
                     last_in = prv_rd_ff;
                  end else begin
                     nxt_we = 1'b1;
                     nxt_wa = prv_rd_ff;
                     nxt_wd = nxt_rd_ff;
                     prv_we = 1'b1;
                     prv_wa = nxt_rd_ff;
                     prv_wd = prv_rd_ff;
                  end
               end
            end else begin
               rd_addr  = nxt_rd_ff;
               steps_in = steps_ff + 1'b1;
            end
         end
         // Load the result register once it is free.
         ole_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_length_in = count_ff;
            end
         end
         default: ;
      endcase
   end

   assign cur_in     = rd_addr;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_length = rsp_length_ff;

   // Memory ports: one write and one registered read each.
   always_ff @(posedge clock) begin
      if (val_we) val_mem[val_wa] <= val_wd;
      if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
      if (prv_we) prv_mem[prv_wa] <= prv_wd;
      if (stk_we) stk_mem[sp_ff[SB-1:0]] <= cur_ff;
      val_rd_ff <= val_mem[rd_addr];
      nxt_rd_ff <= nxt_mem[rd_addr];
      prv_rd_ff <= prv_mem[rd_addr];
      stk_rd_ff <= stk_mem[stk_raddr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ole_pkg::S_IDLE;
         count_ff     <= '0;
         first_ff     <= '0;
         last_ff      <= '0;
         bump_ff      <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         bump_ff      <= bump_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      slot_ff       <= slot_in;
      cur_ff        <= cur_in;
      after_ff      <= after_in;
      steps_ff      <= steps_in;
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
   end

   // Checks.
   `OLE_ASSERT(a_count_bound, count_ff <= CB'(ole_pkg::DEPTH), "entry count above capacity")
   `OLE_ASSERT(a_slot_books, state_ff != ole_pkg::S_IDLE || count_ff == bump_ff - sp_ff, "slot accounting lost")
   `OLE_ASSERT_NEXT(a_busy, accept, state_ff != ole_pkg::S_IDLE, "request taken without work")
   `OLE_ASSERT_NEXT(a_result, state_ff == ole_pkg::S_DONE && out_free, rsp_valid_ff, "result not presented")

endmodule

`default_nettype wire
